@@ rtl/core/pswsplit_pkg.sv @@
package pswsplit_pkg;

  // Characters that steer the splitter
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Quoting context, one-hot
  typedef enum logic [2:0] {
    QM_NONE   = 3'b001,
    QM_SINGLE = 3'b010,
    QM_DOUBLE = 3'b100
  } qmode_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       arg_done;
    logic       null_error;
    logic       run_last;
  } res_t;

  localparam res_t RES_NONE = '{out_byte: 8'h00, has_byte: 1'b0, arg_done: 1'b0,
                                null_error: 1'b0, run_last: 1'b0};

endpackage

@@ rtl/core/pswsplit_if.sv @@
// Input channel: one byte of the command line per request
interface pswsplit_in_if;
  import pswsplit_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

// Output channel: one result per request
interface pswsplit_out_if;
  import pswsplit_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       arg_done;
  logic       null_error;
  logic       run_last;

  modport source (output valid, output out_byte, output has_byte, output arg_done,
                  output null_error, output run_last, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input arg_done,
                  input null_error, input run_last, output ready);
endinterface

@@ rtl/core/pswsplit_decode.sv @@
module pswsplit_decode
  import pswsplit_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       is_final,
  input  logic       adv,
  output res_t       res0,
  output res_t       res1,
  output logic [1:0] n
);

  qmode_t quote_mode, quote_mode_next;
  logic   escape_pending, escape_pending_next;
  logic   word_open, word_open_next;

  always_comb begin
    logic [7:0] b0, b1;
    logic [1:0] nb;
    logic       delim, done;
    logic       in_dq, in_sq;
    qmode_t     qm;
    logic       esc;

    b0 = CH_NUL;
    b1 = CH_NUL;
    nb = 2'd0;
    delim = 1'b0;
    done = 1'b0;
    in_dq = (quote_mode == QM_DOUBLE);
    in_sq = (quote_mode == QM_SINGLE);
    qm = quote_mode;
    esc = escape_pending;
    res0 = RES_NONE;
    res1 = RES_NONE;
    n = 2'd0;
    quote_mode_next = quote_mode;
    escape_pending_next = escape_pending;
    word_open_next = word_open;

    if (in_byte == CH_NUL) begin
      // zero byte: flag it and drop the partial argument
      res0.null_error = 1'b1;
      res0.run_last = 1'b1;
      n = 2'd1;
      quote_mode_next = QM_NONE;
      escape_pending_next = 1'b0;
      word_open_next = 1'b0;
    end else begin
      // byte classification per quoting context
      if (esc) begin
        if (in_dq && !(in_byte == CH_BSLASH || in_byte == CH_DQUOTE)) begin
          b0 = CH_BSLASH;
          b1 = in_byte;
          nb = 2'd2;
        end else begin
          b0 = in_byte;
          nb = 2'd1;
        end
        esc = 1'b0;
      end else if (in_sq) begin
        if (in_byte == CH_SQUOTE) qm = QM_NONE;
        else begin
          b0 = in_byte;
          nb = 2'd1;
        end
      end else if (in_dq) begin
        if (in_byte == CH_DQUOTE) qm = QM_NONE;
        else if (in_byte == CH_BSLASH) esc = 1'b1;
        else begin
          b0 = in_byte;
          nb = 2'd1;
        end
      end else begin
        if (in_byte == CH_SPACE || in_byte == CH_TAB) begin
          delim = 1'b1;
          done = word_open;
        end else if (in_byte == CH_DQUOTE) qm = QM_DOUBLE;
        else if (in_byte == CH_SQUOTE) qm = QM_SINGLE;
        else if (in_byte == CH_BSLASH) esc = 1'b1;
        else begin
          b0 = in_byte;
          nb = 2'd1;
        end
      end

      quote_mode_next = qm;
      escape_pending_next = esc;
      word_open_next = !delim;

      // end of string: emit a held backslash in double quotes, close, clear
      if (is_final) begin
        if (esc && qm == QM_DOUBLE && nb != 2'd2) begin
          if (nb == 2'd0) b0 = CH_BSLASH;
          else b1 = CH_BSLASH;
          nb = nb + 2'd1;
        end
        if (!delim) done = 1'b1;
        quote_mode_next = QM_NONE;
        escape_pending_next = 1'b0;
        word_open_next = 1'b0;
      end

      // pack results
      unique case (nb)
        2'd0: begin
          if (done) begin
            res0.arg_done = 1'b1;
            res0.run_last = 1'b1;
            n = 2'd1;
          end
        end
        2'd1: begin
          res0.out_byte = b0;
          res0.has_byte = 1'b1;
          res0.arg_done = done;
          res0.run_last = 1'b1;
          n = 2'd1;
        end
        default: begin
          res0.out_byte = b0;
          res0.has_byte = 1'b1;
          res1.out_byte = b1;
          res1.has_byte = 1'b1;
          res1.arg_done = done;
          res1.run_last = 1'b1;
          n = 2'd2;
        end
      endcase
    end
  end

  // state advances as the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode <= QM_NONE;
      escape_pending <= 1'b0;
      word_open <= 1'b0;
    end else if (adv) begin
      quote_mode <= quote_mode_next;
      escape_pending <= escape_pending_next;
      word_open <= word_open_next;
    end
  end

endmodule

@@ rtl/core/pswsplit_outq.sv @@
module pswsplit_outq
  import pswsplit_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  res_t       res0,
  input  res_t       res1,
  input  logic [1:0] n,
  output logic [1:0] free,
  output logic       deq_valid,
  input  logic       deq_ready,
  output res_t       head
);

  res_t       ent [2];
  res_t       ent_next [2];
  logic [1:0] cnt, cnt_next;
  logic       pop;
  logic [1:0] rem;

  assign pop = (cnt != 2'd0) && deq_ready;
  assign rem = cnt - {1'b0, pop};
  assign free = 2'd2 - rem;
  assign deq_valid = (cnt != 2'd0);
  assign head = ent[0];

  // shift out the head, then append the new results behind what remains
  always_comb begin
    ent_next[0] = pop ? ent[1] : ent[0];
    ent_next[1] = ent[1];
    if (n != 2'd0) begin
      if (rem == 2'd0) begin
        ent_next[0] = res0;
        ent_next[1] = res1;
      end else begin
        ent_next[1] = res0;
      end
    end
    cnt_next = rem + n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    ent[0] <= ent_next[0];
    ent[1] <= ent_next[1];
  end

endmodule

@@ rtl/core/posix_shell_word_splitter_core.sv @@
// POSIX-style command-line word splitter.
// text: one byte of the command line per request, is_final on the last byte.
// args: one result per request; a byte of the current argument (has_byte),
//   an end-of-argument mark (arg_done), or a zero-byte error (null_error).
//   run_last marks the last result caused by an input byte.
// An input byte gives zero, one or two results; bytes that add nothing
// (opening quotes, a held backslash, repeated blanks) give none.
// An accepted byte is decoded from the input register into the result queue.
// Throughput: one byte per cycle while the result queue has room; args moves
//   one result per cycle, so a byte that makes two results needs a second
//   transfer on args. Once the two-entry result queue holds a backlog, a byte
//   waits in the input register until the queue has room for all of its results.
// Reset (rst, synchronous) empties the input register and the result queue
//   and returns the quoting state to outside quotes with nothing pending.
// When the receiver stalls, results wait in the queue and the input register
//   keeps taking bytes until the byte it holds no longer fits, then text.ready falls.
module posix_shell_word_splitter_core
  import pswsplit_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  pswsplit_in_if.sink           text,
  pswsplit_out_if.source        args
);

  logic       vq;
  logic [7:0] byte_q;
  logic       final_q;
  logic       adv;
  res_t       res0, res1, head;
  logic [1:0] n, free;

  // item moves on when the queue has room for all its results
  assign adv = vq && (n <= free);
  assign text.ready = !vq || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= 1'b0;
    end else if (text.valid && text.ready) begin
      vq <= 1'b1;
    end else if (adv) begin
      vq <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      byte_q <= text.in_byte;
      final_q <= text.is_final;
    end
  end

  pswsplit_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .in_byte  (byte_q),
    .is_final (final_q),
    .adv      (adv),
    .res0     (res0),
    .res1     (res1),
    .n        (n)
  );

  pswsplit_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res0      (res0),
    .res1      (res1),
    .n         (adv ? n : 2'd0),
    .free      (free),
    .deq_valid (args.valid),
    .deq_ready (args.ready),
    .head      (head)
  );

  assign args.out_byte   = head.out_byte;
  assign args.has_byte   = head.has_byte;
  assign args.arg_done   = head.arg_done;
  assign args.null_error = head.null_error;
  assign args.run_last   = head.run_last;

endmodule

@@ rtl/core/pswsplit_checker.sv @@
module pswsplit_checker
  import pswsplit_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic [7:0] out_byte,
  input logic       has_byte,
  input logic       arg_done,
  input logic       null_error,
  input logic       run_last
);

  // nothing offered straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !valid)
    else $error("result offered after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(out_byte) && $stable(has_byte)
      && $stable(arg_done) && $stable(null_error) && $stable(run_last))
    else $error("stalled result changed");

  // an error result stands alone
  a_err: assert property (@(posedge clk) disable iff (rst)
    valid && null_error |-> !has_byte && !arg_done && run_last && out_byte == CH_NUL)
    else $error("malformed error result");

  // a result without a byte must close an argument or report an error
  a_empty: assert property (@(posedge clk) disable iff (rst)
    valid && !has_byte |-> out_byte == CH_NUL && run_last && (arg_done || null_error))
    else $error("empty result carries nothing");

endmodule

bind posix_shell_word_splitter_core pswsplit_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .valid      (args.valid),
  .ready      (args.ready),
  .out_byte   (args.out_byte),
  .has_byte   (args.has_byte),
  .arg_done   (args.arg_done),
  .null_error (args.null_error),
  .run_last   (args.run_last)
);
